/* rtl/firc_pkg.sv */
package firc_pkg;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int VALUE_W  = 42;
    localparam int PROD_W   = SAMPLE_W + COEF_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_MAC,
        ST_CREAD,
        ST_DONE
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic [VALUE_W-1:0]         value_t;

endpackage

/* rtl/firc_if.sv */
interface firc_in_if;
    logic                            valid;
    logic                            ready;
    firc_pkg::cmd_t                  cmd;
    firc_pkg::sample_t               sample;
    logic [firc_pkg::INDEX_W-1:0]    tap_index;
    firc_pkg::coef_t                 coef_value;

    modport source (output valid, output cmd, output sample, output tap_index,
                    output coef_value, input ready);
    modport sink   (input valid, input cmd, input sample, input tap_index,
                    input coef_value, output ready);
endinterface

interface firc_out_if;
    logic              valid;
    logic              ready;
    firc_pkg::value_t  value;
    logic              is_tap_read;

    modport source (output valid, output value, output is_tap_read, input ready);
    modport sink   (input valid, input value, input is_tap_read, output ready);
endinterface

/* rtl/fir_filter_circular.sv */
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    cmd, sample, tap_index, coef_value
// rsp       out  valid/ready    value, is_tap_read
// cfg       in   cfg_we         cfg_wdata (tap_count)
//
// Filter item: one multiply-accumulate walks the taps, one per cycle, reading history and
// coefficient memories in lockstep. Fill item: one history write per cycle. After reset a
// clearing pass writes zeros to all MAX_TAPS history entries; req.ready stays low during the
// pass. A stalled rsp holds its item; the next req item is taken while it waits, and its own
// result waits until the output register frees.
module fir_filter_circular #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    firc_in_if.sink                       req,
    firc_out_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [firc_pkg::COUNT_W-1:0]  cfg_wdata
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);

    firc_pkg::state_t state_reg, state_next;

    logic [firc_pkg::COUNT_W-1:0] tap_count_reg;
    logic [CNT_W-1:0]  taps_n;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              prod_vld_reg, prod_vld_next;
    logic              out_valid_reg, out_valid_next;

    firc_pkg::sample_t fill_val_reg, fill_val_next;
    logic              hit_reg, hit_next;
    logic              res_tap_reg, res_tap_next;
    firc_pkg::value_t  acc_reg, acc_next;
    firc_pkg::prod_t   prod_reg;
    firc_pkg::value_t  out_value_reg, out_value_next;
    logic              out_tap_reg, out_tap_next;

    firc_pkg::sample_t hist_mem [MAX_TAPS];
    firc_pkg::coef_t   coef_mem [MAX_TAPS];
    firc_pkg::sample_t hist_q;
    firc_pkg::coef_t   coef_q;

    logic              accept;
    logic [ADDR_W-1:0] p_cur, p_inc, rp_inc;
    logic              issue, mac_done, fill_last, clear_last, out_load;

    logic              hist_we;
    logic [ADDR_W-1:0] hist_waddr;
    firc_pkg::sample_t hist_wdata;
    logic              coef_we;
    logic              coef_re;
    logic [ADDR_W-1:0] coef_raddr;

    assign req.ready = (state_reg == firc_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Clamp tap_count into 1..MAX_TAPS.
    always_comb
    begin
        if (tap_count_reg == '0)
            taps_n = CNT_W'(1);
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
            taps_n = CNT_W'(MAX_TAPS);
        else
            taps_n = CNT_W'(tap_count_reg);
    end

    // Stale pointer after tap_count shrank acts as zero.
    assign p_cur  = (CNT_W'(wp_reg) < taps_n) ? wp_reg : '0;
    assign p_inc  = ((CNT_W'(p_cur) + CNT_W'(1)) >= taps_n) ? '0 : (p_cur + ADDR_W'(1));
    assign rp_inc = ((CNT_W'(rp_reg) + CNT_W'(1)) >= taps_n) ? '0 : (rp_reg + ADDR_W'(1));

    assign issue      = (state_reg == firc_pkg::ST_MAC) && (cnt_reg != taps_n);
    assign mac_done   = (state_reg == firc_pkg::ST_MAC) && !issue && !rd_vld_reg
                        && !prod_vld_reg;
    assign fill_last  = ((cnt_reg + CNT_W'(1)) == taps_n);
    assign clear_last = (cnt_reg == CNT_W'(MAX_TAPS - 1));
    assign out_load   = (state_reg == firc_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            firc_pkg::ST_CLEAR:
            begin
                if (clear_last)
                    state_next = firc_pkg::ST_IDLE;
            end
            firc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        firc_pkg::CMD_FILTER: state_next = firc_pkg::ST_MAC;
                        firc_pkg::CMD_FILL:   state_next = firc_pkg::ST_FILL;
                        firc_pkg::CMD_READ:   state_next = firc_pkg::ST_CREAD;
                        default:              state_next = firc_pkg::ST_IDLE;
                    endcase
                end
            end
            firc_pkg::ST_FILL:
            begin
                if (fill_last)
                    state_next = firc_pkg::ST_IDLE;
            end
            firc_pkg::ST_MAC:
            begin
                if (mac_done)
                    state_next = firc_pkg::ST_DONE;
            end
            firc_pkg::ST_CREAD:
            begin
                state_next = firc_pkg::ST_DONE;
            end
            firc_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = firc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = firc_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory strobes
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = cnt_reg[ADDR_W-1:0];
        hist_wdata = '0;
        coef_we    = 1'b0;
        coef_re    = 1'b0;
        coef_raddr = cnt_reg[ADDR_W-1:0];
        case (state_reg)
            firc_pkg::ST_CLEAR:
            begin
                hist_we = 1'b1;
            end
            firc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        firc_pkg::CMD_FILTER:
                        begin
                            hist_we    = 1'b1;
                            hist_waddr = p_cur;
                            hist_wdata = req.sample;
                        end
                        firc_pkg::CMD_LOAD:
                        begin
                            coef_we = (32'(req.tap_index) < 32'(MAX_TAPS));
                        end
                        firc_pkg::CMD_READ:
                        begin
                            coef_re    = 1'b1;
                            coef_raddr = ADDR_W'(req.tap_index);
                        end
                        default:
                        begin
                            hist_we = 1'b0;
                        end
                    endcase
                end
            end
            firc_pkg::ST_FILL:
            begin
                hist_we    = 1'b1;
                hist_wdata = fill_val_reg;
            end
            firc_pkg::ST_MAC:
            begin
                coef_re = issue;
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_val_next  = fill_val_reg;
        hit_next       = hit_reg;
        res_tap_next   = res_tap_reg;
        acc_next       = acc_reg;
        rd_vld_next    = issue;
        prod_vld_next  = rd_vld_reg;
        case (state_reg)
            firc_pkg::ST_CLEAR:
            begin
                cnt_next = clear_last ? '0 : (cnt_reg + CNT_W'(1));
            end
            firc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    case (req.cmd)
                        firc_pkg::CMD_FILTER:
                        begin
                            wp_next      = p_inc;
                            rp_next      = p_inc;
                            acc_next     = '0;
                            res_tap_next = 1'b0;
                        end
                        firc_pkg::CMD_FILL:
                        begin
                            fill_val_next = req.sample;
                            wp_next       = '0;
                        end
                        firc_pkg::CMD_READ:
                        begin
                            hit_next     = (32'(req.tap_index) < 32'(taps_n));
                            res_tap_next = 1'b1;
                        end
                        default:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            firc_pkg::ST_FILL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            firc_pkg::ST_MAC:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    rp_next  = rp_inc;
                end
                if (prod_vld_reg)
                    acc_next = acc_reg + firc_pkg::VALUE_W'(prod_reg);
            end
            firc_pkg::ST_CREAD:
            begin
                acc_next = hit_reg ? firc_pkg::VALUE_W'(coef_q) : '0;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Output register: hold the item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_tap_next   = out_tap_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_value_next = acc_reg;
            out_tap_next   = res_tap_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= firc_pkg::ST_CLEAR;
            tap_count_reg <= firc_pkg::COUNT_W'(1);
            cnt_reg       <= '0;
            wp_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                tap_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg        <= rp_next;
        fill_val_reg  <= fill_val_next;
        hit_reg       <= hit_next;
        res_tap_reg   <= res_tap_next;
        acc_reg       <= acc_next;
        prod_reg      <= hist_q * coef_q;
        out_value_reg <= out_value_next;
        out_tap_reg   <= out_tap_next;
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        if (issue)
            hist_q <= hist_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[ADDR_W'(req.tap_index)] <= req.coef_value;
        if (coef_re)
            coef_q <= coef_mem[coef_raddr];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.value       = out_value_reg;
    assign rsp.is_tap_read = out_tap_reg;

endmodule

/* rtl/firc_checker.sv */
module firc_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input firc_pkg::cmd_t          req_cmd,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input firc_pkg::value_t        rsp_value,
    input logic                    rsp_is_tap_read
);

    logic req_take;

    assign req_take = req_valid && req_ready;

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_is_tap_read))
        else $error("rsp payload changed while stalled");

    // Only a coefficient load leaves the block ready for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take && (req_cmd != firc_pkg::CMD_LOAD) |=> !req_ready)
        else $error("req ready right after a multi-cycle item");

    // A result never shows up the cycle right after its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take && (req_cmd == firc_pkg::CMD_FILTER || req_cmd == firc_pkg::CMD_READ)
        |=> !$rose(rsp_valid))
        else $error("result appeared too early");

    // A new result is loaded only while input is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result loaded while idle");

endmodule

bind fir_filter_circular firc_checker u_firc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_cmd         (req.cmd),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_value       (rsp.value),
    .rsp_is_tap_read (rsp.is_tap_read)
);
